// ===== hdl/linear_prime_sieve_defines.svh =====
// Assertion macros for the prime sieve.
`ifndef LINEAR_PRIME_SIEVE_DEFINES_SVH
`define LINEAR_PRIME_SIEVE_DEFINES_SVH

// Same-cycle implication.
`define LPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lps_pkg.sv =====
package lps_pkg;

  localparam int unsigned MAX_N      = 65536;
  localparam int unsigned MAX_PRIMES = 8192;

  localparam int unsigned NW    = $clog2(MAX_N);
  localparam int unsigned LW    = $clog2(MAX_N + 1);
  localparam int unsigned PW    = $clog2(MAX_PRIMES);
  localparam int unsigned CW    = $clog2(MAX_PRIMES + 1);
  localparam int unsigned PRODW = 2 * NW;
  localparam int unsigned SW    = $clog2(NW);

  localparam int unsigned CFG_W  = 17;
  localparam int unsigned CAND_W = 16;
  localparam int unsigned CNT_W  = 14;

  localparam logic [LW-1:0] LIM_MAX   = LW'(MAX_N);
  localparam logic [LW-1:0] LIM_MIN   = LW'(3);
  localparam logic [LW-1:0] FIRST_CND = LW'(2);

  function automatic logic [LW-1:0] sat_limit(input logic [CFG_W-1:0] v);
    logic [LW-1:0] r;
    if (v > CFG_W'(MAX_N)) begin
      r = LIM_MAX;
    end else if (v < CFG_W'(3)) begin
      r = LIM_MIN;
    end else begin
      r = LW'(v);
    end
    return r;
  endfunction

endpackage

// ===== hdl/linear_prime_sieve.sv =====
// Channel  | valid       | stall       | payload
// ---------+-------------+-------------+--------------------------------------------
// in       | in_valid_i  | in_stall_o  | in_restart_i
// out      | out_valid_o | out_stall_i | out_candidate_o, out_is_prime_o,
//          |             |             | out_primes_found_o, out_last_o
// cfg      | cfg_we_i    | -           | cfg_sieve_limit_i
//
// One item at a time: a transfer passes CHECK and EVAL, then each stored prime walked
// passes TREAD, TMUL and TMARK, plus a bit-serial remainder in DIV on each prime not above
// the candidate; a finished sieve goes to FIN. Input is taken the cycle after the load.
// A restart first clears the bitmap up to its highest marked entry, one entry a cycle.
// After reset the whole bitmap (MAX_N entries) is cleared, one a cycle, before the first
// transfer is taken. A stalled output holds; the next item may start meanwhile.
module linear_prime_sieve (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lps_pkg::CFG_W-1:0]    cfg_sieve_limit_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_restart_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lps_pkg::CAND_W-1:0]   out_candidate_o,
  output logic                         out_is_prime_o,
  output logic [lps_pkg::CNT_W-1:0]    out_primes_found_o,
  output logic                         out_last_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_EVAL  = 4'd3;
  localparam logic [3:0] ST_TREAD = 4'd4;
  localparam logic [3:0] ST_TMUL  = 4'd5;
  localparam logic [3:0] ST_TMARK = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  localparam int unsigned NW    = lps_pkg::NW;
  localparam int unsigned LW    = lps_pkg::LW;
  localparam int unsigned PW    = lps_pkg::PW;
  localparam int unsigned CW    = lps_pkg::CW;
  localparam int unsigned PRODW = lps_pkg::PRODW;
  localparam int unsigned SW    = lps_pkg::SW;

  logic [3:0]       state_q, state_d;
  logic             pend_q, pend_d;
  logic [LW-1:0]    lim_q, lim_d;
  logic [LW-1:0]    next_q, next_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [LW-1:0]    hw_q, hw_d;
  logic [NW-1:0]    clr_q, clr_d;
  logic             out_valid_q, out_valid_d;

  logic [NW-1:0]    cand_q, cand_d;
  logic             prime_q, prime_d;
  logic             last_q, last_d;
  logic [CW-1:0]    j_q, j_d;
  logic [NW-1:0]    p_q, p_d;
  logic [PRODW-1:0] prod_q, prod_d;
  logic [NW-1:0]    rem_q, rem_d;
  logic [NW-1:0]    dvd_q, dvd_d;
  logic [SW-1:0]    step_q, step_d;

  localparam int unsigned CAND_W_L = lps_pkg::CAND_W;
  logic [CAND_W_L-1:0] out_cand_q;
  logic             out_prime_q;
  logic [lps_pkg::CNT_W-1:0] out_cnt_q;
  logic             out_last_q;
  logic             out_ld;

  logic             map_mem [lps_pkg::MAX_N];
  logic             map_we;
  logic [NW-1:0]    map_waddr;
  logic             map_wdata;
  logic [NW-1:0]    map_raddr;
  logic             map_rd_q;

  logic [NW-1:0]    tbl_mem [lps_pkg::MAX_PRIMES];
  logic             tbl_we;
  logic [PW-1:0]    tbl_raddr;
  logic [NW-1:0]    tbl_rd_q;

  logic [NW:0]      div_sh;
  logic             div_ge;
  logic [NW-1:0]    rem_nx;

  assign div_sh = {rem_q, dvd_q[NW-1]};
  assign div_ge = div_sh >= {1'b0, p_q};
  assign rem_nx = div_ge ? NW'(div_sh - {1'b0, p_q}) : div_sh[NW-1:0];

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    lim_d       = lim_q;
    next_d      = next_q;
    cnt_d       = cnt_q;
    hw_d        = hw_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    cand_d      = cand_q;
    prime_d     = prime_q;
    last_d      = last_q;
    j_d         = j_q;
    p_d         = p_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    step_d      = step_q;
    out_ld      = 1'b0;
    map_we      = 1'b0;
    map_waddr   = clr_q;
    map_wdata   = 1'b0;
    map_raddr   = next_q[NW-1:0];
    tbl_we      = 1'b0;
    tbl_raddr   = j_q[PW-1:0];

    if (cfg_we_i) begin
      lim_d = lps_pkg::sat_limit(cfg_sieve_limit_i);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pend_d = 1'b1;
          if (in_restart_i) begin
            clr_d   = '0;
            state_d = ST_CLR;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CLR: begin
        if (hw_q != '0) begin
          map_we = 1'b1;
          clr_d  = clr_q + NW'(1);
        end
        if (hw_q == '0 || LW'(clr_q) == hw_q - LW'(1)) begin
          cnt_d   = '0;
          next_d  = lps_pkg::FIRST_CND;
          hw_d    = '0;
          clr_d   = '0;
          state_d = pend_q ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (next_q >= lim_q) begin
          cand_d  = '0;
          prime_d = 1'b0;
          last_d  = 1'b1;
          state_d = ST_FIN;
        end else begin
          cand_d  = next_q[NW-1:0];
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        prime_d = !map_rd_q;
        last_d  = (LW'(cand_q) == lim_q - LW'(1));
        next_d  = LW'(cand_q) + LW'(1);
        if (!map_rd_q && cnt_q < CW'(lps_pkg::MAX_PRIMES)) begin
          tbl_we = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
        j_d     = '0;
        state_d = ST_TREAD;
      end
      ST_TREAD: begin
        state_d = (j_q >= cnt_q) ? ST_FIN : ST_TMUL;
      end
      ST_TMUL: begin
        p_d     = tbl_rd_q;
        prod_d  = PRODW'(cand_q) * PRODW'(tbl_rd_q);
        state_d = ST_TMARK;
      end
      ST_TMARK: begin
        if (p_q == '0 || prod_q >= PRODW'(lim_q)) begin
          state_d = ST_FIN;
        end else begin
          map_we    = 1'b1;
          map_waddr = prod_q[NW-1:0];
          map_wdata = 1'b1;
          if (LW'(prod_q[NW-1:0]) >= hw_q) begin
            hw_d = LW'(prod_q[NW-1:0]) + LW'(1);
          end
          if (p_q > cand_q) begin
            j_d     = j_q + CW'(1);
            state_d = ST_TREAD;
          end else begin
            rem_d   = '0;
            dvd_d   = cand_q;
            step_d  = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d  = rem_nx;
        dvd_d  = dvd_q << 1;
        step_d = step_q + SW'(1);
        if (step_q == SW'(NW - 1)) begin
          if (rem_nx == '0) begin
            state_d = ST_FIN;
          end else begin
            j_d     = j_q + CW'(1);
            state_d = ST_TREAD;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
          pend_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      pend_q      <= 1'b0;
      lim_q       <= lps_pkg::LIM_MAX;
      next_q      <= lps_pkg::FIRST_CND;
      cnt_q       <= '0;
      hw_q        <= lps_pkg::LIM_MAX;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      lim_q       <= lim_d;
      next_q      <= next_d;
      cnt_q       <= cnt_d;
      hw_q        <= hw_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    prime_q <= prime_d;
    last_q  <= last_d;
    j_q     <= j_d;
    p_q     <= p_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    step_q  <= step_d;
    if (out_ld) begin
      out_cand_q  <= CAND_W_L'(cand_q);
      out_prime_q <= prime_q;
      out_cnt_q   <= lps_pkg::CNT_W'(cnt_q);
      out_last_q  <= last_q;
    end
  end

  // composite bitmap
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    map_rd_q <= map_mem[map_raddr];
  end

  // prime table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[cnt_q[PW-1:0]] <= cand_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tbl_rd_q <= tbl_mem[tbl_raddr];
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign out_candidate_o    = out_cand_q;
  assign out_is_prime_o     = out_prime_q;
  assign out_primes_found_o = out_cnt_q;
  assign out_last_o         = out_last_q;

endmodule

// ===== hdl/lps_checker.sv =====
`include "linear_prime_sieve_defines.svh"

module lps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [lps_pkg::CAND_W-1:0]   out_candidate_o,
  input logic                         out_is_prime_o,
  input logic [lps_pkg::CNT_W-1:0]    out_primes_found_o,
  input logic                         out_last_o
);

  // a transfer starts a multi-cycle item
  `LPS_ASSERT_NXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o,
                  "no stall after transfer")

  // candidate zero only reports the finished sieve
  `LPS_ASSERT_IMP(a_done_form, out_valid_o && out_candidate_o == '0,
                  out_last_o && !out_is_prime_o, "bad finished result")

  // a prime result always leaves a non-empty count
  `LPS_ASSERT_IMP(a_prime_cnt, out_valid_o && out_is_prime_o,
                  out_primes_found_o != '0 && out_candidate_o >= lps_pkg::CAND_W'(2),
                  "prime with empty count")

  `LPS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
                  out_valid_o && $stable(out_candidate_o) && $stable(out_primes_found_o),
                  "stalled result changed")

endmodule

bind linear_prime_sieve lps_checker u_lps_checker (.*);

// ===== bench/linear_prime_sieve_check.sv =====
`timescale 1ns / 100ps

module linear_prime_sieve_check
  import lps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_sieve_limit_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              in_restart_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [CAND_W-1:0] out_candidate_i,
  input  logic              out_is_prime_i,
  input  logic [CNT_W-1:0]  out_primes_found_i,
  input  logic              out_last_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [CAND_W-1:0] cand;
    logic              is_prime;
    logic [CNT_W-1:0]  found;
    logic              last;
  } sieve_res_t;

  bit                composite_q [MAX_N];
  logic [CAND_W-1:0] prime_tab   [MAX_PRIMES];
  int unsigned       n_primes;
  int unsigned       next_cand;
  logic [CFG_W-1:0]  limit_reg;
  sieve_res_t        sieve_exp_q [$];

  task automatic flag(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: ERROR %s", $realtime, msg);
    end
  endtask

  task automatic sieve_tick(input logic restart);
    int unsigned     lim;
    int unsigned     c;
    int unsigned     p;
    longint unsigned prod;
    bit              prime;
    sieve_res_t      r;
    if (restart) begin
      foreach (composite_q[i]) composite_q[i] = 1'b0;
      n_primes  = 0;
      next_cand = 2;
    end
    lim = limit_reg;
    if (lim > MAX_N) lim = MAX_N;
    if (lim < 3) lim = 3;
    if (next_cand >= lim) begin
      r.cand     = '0;
      r.is_prime = 1'b0;
      r.found    = CNT_W'(n_primes);
      r.last     = 1'b1;
    end else begin
      c     = next_cand;
      prime = !composite_q[c];
      if (prime && n_primes < MAX_PRIMES) begin
        prime_tab[n_primes] = CAND_W'(c);
        n_primes++;
      end
      for (int unsigned j = 0; j < n_primes; j++) begin
        p    = prime_tab[j];
        prod = longint'(c) * longint'(p);
        if (p == 0 || prod >= lim) break;
        composite_q[prod] = 1'b1;
        if (c % p == 0) break;
      end
      next_cand  = c + 1;
      r.cand     = CAND_W'(c);
      r.is_prime = prime;
      r.found    = CNT_W'(n_primes);
      r.last     = (c == lim - 1);
    end
    sieve_exp_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    sieve_res_t e;
    if (!rst_ni) begin
      foreach (composite_q[i]) composite_q[i] = 1'b0;
      n_primes     = 0;
      next_cand    = 2;
      limit_reg    = CFG_W'(MAX_N);
      sieve_exp_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) limit_reg = cfg_sieve_limit_i;
      if (in_valid_i && !in_stall_i) sieve_tick(in_restart_i);
      if (out_valid_i && !out_stall_i) begin
        if (sieve_exp_q.size() == 0) begin
          flag($sformatf("unexpected result transfer, cand=%0d", out_candidate_i));
        end else begin
          e = sieve_exp_q.pop_front();
          if (e.cand !== out_candidate_i || e.is_prime !== out_is_prime_i ||
              e.found !== out_primes_found_i || e.last !== out_last_i) begin
            flag($sformatf({"result differs: exp cand=%0d prime=%0d found=%0d last=%0d,",
                            " got cand=%0d prime=%0d found=%0d last=%0d"},
                           e.cand, e.is_prime, e.found, e.last, out_candidate_i,
                           out_is_prime_i, out_primes_found_i, out_last_i));
          end
        end
      end
      pending_o = sieve_exp_q.size();
    end
  end

endmodule

// ===== bench/linear_prime_sieve_test.sv =====
`timescale 1ns / 100ps

module linear_prime_sieve_test;
  import lps_pkg::*;

  localparam int unsigned N_ITEMS         = 1150;
  localparam int unsigned WATCHDOG_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES     = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_sieve_limit_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              in_restart_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CAND_W-1:0] out_candidate_o;
  logic              out_is_prime_o;
  logic [CNT_W-1:0]  out_primes_found_o;
  logic              out_last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_go;
  bit          hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  linear_prime_sieve dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_sieve_limit_i  (cfg_sieve_limit_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_restart_i       (in_restart_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_candidate_o    (out_candidate_o),
    .out_is_prime_o     (out_is_prime_o),
    .out_primes_found_o (out_primes_found_o),
    .out_last_o         (out_last_o)
  );

  linear_prime_sieve_check chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_sieve_limit_i  (cfg_sieve_limit_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .in_restart_i       (in_restart_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_candidate_i    (out_candidate_o),
    .out_is_prime_i     (out_is_prime_o),
    .out_primes_found_i (out_primes_found_o),
    .out_last_i         (out_last_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // receiver: random stall, plus one long hold-off on request
  always begin
    @(negedge clk_i);
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      out_stall_i <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
    end
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("linear_prime_sieve: mismatch");
    $finish;
  end

  task automatic send_tick(input logic restart);
    if (sent < N_ITEMS / 3) begin
      tx_idle_pct = 7;
      rx_idle_pct = 59;
    end else if (sent < 2 * N_ITEMS / 3) begin
      tx_idle_pct = 59;
      rx_idle_pct = 7;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_restart_i <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_we_i          <= 1'b1;
    cfg_sieve_limit_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] lim;
    int unsigned      n;
    bit               fresh;
    bit               held;
    bit               paused;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_sieve_limit_i = '0;
    in_valid_i        = 1'b0;
    in_restart_i      = 1'b0;
    hold_go           = 1'b0;
    sent              = 0;
    tx_idle_pct       = 7;
    rx_idle_pct       = 59;
    held              = 1'b0;
    paused            = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset limit: small primes and composites, then restart
    repeat (12) send_tick(1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    // minimum limit: finished sieve, restart onto the last candidate
    drain();
    write_limit(CFG_W'(3));
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    // below range saturates up
    drain();
    write_limit('0);
    send_tick(1'b1);
    // above range saturates down, run carries on
    drain();
    write_limit('1);
    repeat (2) send_tick(1'b0);
    drain();
    write_limit(CFG_W'(5));
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);

    while (sent < N_ITEMS) begin
      drain();
      case ($urandom_range(29))
        0:       lim = CFG_W'($urandom_range(2));
        1:       lim = CFG_W'($urandom_range(131071, 65537));
        2:       lim = CFG_W'(MAX_N);
        3:       lim = CFG_W'($urandom_range(65535, 1000));
        default: lim = CFG_W'($urandom_range(300, 3));
      endcase
      write_limit(lim);
      n     = $urandom_range(60, 20);
      fresh = ($urandom_range(3) != 0);
      for (int unsigned i = 0; i < n; i++) begin
        send_tick((i == 0 && fresh) || ($urandom_range(49) == 0));
        if (!held && sent >= 500) begin
          held    = 1'b1;
          hold_go = 1'b1;
        end
        if (!paused && sent >= 700) begin
          paused = 1'b1;
          drain();
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("linear_prime_sieve: match");
    end else begin
      $display("linear_prime_sieve: mismatch");
    end
    $finish;
  end

endmodule
